@@ hdl/tbf_pkg.sv @@
// Package for the three-hash Bloom filter: transaction structs, sequencer states,
// hash control struct and hash constants. No dependencies.
package tbf_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_byte;
    logic       last;
  } tbf_item_t;

  typedef struct packed {
    logic found;
    logic was_insert;
  } tbf_result_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_MM1, S_MM2, S_MM3, S_FT1, S_FT2, S_FX0, S_FX1, S_FX2, S_FX3,
    S_W1, S_W2, S_W3, S_R1, S_R2, S_R3, S_R4
  } tbf_state_t;

  typedef struct packed {
    logic load;
    logic mm1;
    logic mm2;
    logic mm3;
    logic ft1;
    logic ft2;
    logic fx0;
    logic fx1;
    logic fx2;
    logic fx3;
    logic clear;
  } tbf_hash_ctrl_t;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME_L = 64'h00000000000001b3;
  localparam logic [31:0] MM_SEED     = 32'h9747b28c;
  localparam logic [31:0] MM_C1       = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2       = 32'h1b873593;
  localparam logic [31:0] MM_N        = 32'he6546b64;
  localparam logic [31:0] MM_F1       = 32'h85ebca6b;
  localparam logic [31:0] MM_F2       = 32'hc2b2ae35;

endpackage

@@ hdl/tbf_table.sv @@
// Single-port bit table with registered read.
// Depends on nothing.
module tbf_table #(
  parameter int IDX_W = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] addr,
  input  logic             wdata,
  output logic             rd_data
);

  logic mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

endmodule

@@ hdl/tbf_hash.sv @@
// Hash datapath: FNV-1a 64, one-at-a-time 64 and MurmurHash3 32 accumulators
// with stepped finalisation. Depends on tbf_pkg.
module tbf_hash import tbf_pkg::*; #(
  parameter int IDX_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  tbf_hash_ctrl_t   ctrl,
  input  logic [7:0]       key_byte,
  output logic             block_end,
  output logic [IDX_W-1:0] idx1,
  output logic [IDX_W-1:0] idx2,
  output logic [IDX_W-1:0] idx3
);

  logic [63:0] fnv_acc, oaat_acc, h2;
  logic [31:0] murmur_acc, word_gather, key_length, k, h3;
  logic [63:0] sx, fnv_x, oa_a, oa_b, h2_t;
  logic [31:0] rk, mm_x, mm_r, fx_t, h3_s;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    rotl = (v << r) | (v >> (32 - r));
  endfunction

  always_comb begin
    sx    = {{56{key_byte[7]}}, key_byte};
    fnv_x = fnv_acc ^ sx;
    oa_a  = oaat_acc + sx;
    oa_b  = oa_a + (oa_a << 10);
    h2_t  = oaat_acc + (oaat_acc << 3);
    rk    = rotl(k, 15);
    mm_x  = murmur_acc ^ k;
    mm_r  = rotl(mm_x, 13);
    fx_t  = murmur_acc ^ ((key_length[1:0] != 2'd0) ? k : 32'd0) ^ key_length;
    h3_s  = h3 ^ (h3 >> 13);
  end

  assign block_end = (key_length[1:0] == 2'd3);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      fnv_acc     <= FNV_BASIS;
      oaat_acc    <= 64'd0;
      murmur_acc  <= MM_SEED;
      word_gather <= 32'd0;
      key_length  <= 32'd0;
    end else begin
      if (ctrl.load) begin
        fnv_acc     <= (fnv_x << 40) + fnv_x * FNV_PRIME_L;
        oaat_acc    <= oa_b ^ (oa_b >> 6);
        word_gather <= word_gather | ({24'd0, key_byte} << {key_length[1:0], 3'b000});
        key_length  <= key_length + 32'd1;
      end
      if (ctrl.mm3) begin
        murmur_acc  <= (mm_r << 2) + mm_r + MM_N;
        word_gather <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mm1 || ctrl.ft1) begin
      k <= word_gather * MM_C1;
    end
    if (ctrl.mm2 || ctrl.ft2) begin
      k <= rk * MM_C2;
    end
    if (ctrl.ft1) begin
      h2 <= h2_t ^ (h2_t >> 11);
    end
    if (ctrl.ft2) begin
      h2 <= h2 + (h2 << 15);
    end
    if (ctrl.fx0) begin
      h3 <= fx_t ^ (fx_t >> 16);
    end
    if (ctrl.fx1) begin
      h3 <= h3 * MM_F1;
    end
    if (ctrl.fx2) begin
      h3 <= h3_s * MM_F2;
    end
    if (ctrl.fx3) begin
      h3 <= h3 ^ (h3 >> 16);
    end
  end

  assign idx1 = fnv_acc[IDX_W-1:0];
  assign idx2 = h2[IDX_W-1:0];
  assign idx3 = h3[IDX_W-1:0];

endmodule

@@ hdl/three_hash_bloom_filter.sv @@
// Top level of the three-hash Bloom filter: sequencer, table clearing pass,
// result register. Depends on tbf_pkg, tbf_hash and tbf_table.
//
// A key byte is taken when start is high and busy is low. After an ordinary byte
// the sequencer is idle again; a byte that completes a 4-byte Murmur block first
// runs the registered multiplier steps of the block mix (MM1, MM2, MM3). The last
// byte adds hash finalisation (FT1, FT2, FX0 to FX3), then three table writes
// (insert) or three table reads (lookup) through the single memory port; the
// result strobe, done, is high for one cycle after that and the receiver cannot
// hold it off. After reset the table is cleared one bit per cycle with busy high.
module three_hash_bloom_filter import tbf_pkg::*; #(
  parameter int TABLE_BITS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  tbf_item_t   item,
  output logic        done,
  output tbf_result_t result
);

  localparam int IDX_W = $clog2(TABLE_BITS);

  tbf_state_t     state, state_next;
  tbf_hash_ctrl_t hctrl;
  logic [IDX_W-1:0] clr_addr, idx1, idx2, idx3, mem_addr;
  logic cmd_q, last_q, hit, mem_we, mem_wdata, rd_data, block_end;
  logic done_next, found_next;

  tbf_hash #(.IDX_W(IDX_W)) u_hash (
    .clk(clk), .rst(rst), .ctrl(hctrl), .key_byte(item.key_byte),
    .block_end(block_end), .idx1(idx1), .idx2(idx2), .idx3(idx3)
  );

  tbf_table #(.IDX_W(IDX_W)) u_table (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q  <= item.cmd;
      last_q <= item.last;
    end
    if (state == S_R2) begin
      hit <= rd_data;
    end
    if (state == S_R3) begin
      hit <= hit & rd_data;
    end
    if (done_next) begin
      result.found      <= found_next;
      result.was_insert <= (state == S_W3);
    end
  end

  always_comb begin
    state_next = state;
    hctrl      = '0;
    busy       = 1'b1;
    mem_we     = 1'b0;
    mem_wdata  = 1'b1;
    mem_addr   = idx1;
    done_next  = 1'b0;
    found_next = 1'b0;
    case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        mem_addr  = clr_addr;
        if (clr_addr == {IDX_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          hctrl.load = 1'b1;
          if (block_end) begin
            state_next = S_MM1;
          end else if (item.last) begin
            state_next = S_FT1;
          end
        end
      end
      S_MM1: begin
        hctrl.mm1  = 1'b1;
        state_next = S_MM2;
      end
      S_MM2: begin
        hctrl.mm2  = 1'b1;
        state_next = S_MM3;
      end
      S_MM3: begin
        hctrl.mm3  = 1'b1;
        state_next = last_q ? S_FT1 : S_IDLE;
      end
      S_FT1: begin
        hctrl.ft1  = 1'b1;
        state_next = S_FT2;
      end
      S_FT2: begin
        hctrl.ft2  = 1'b1;
        state_next = S_FX0;
      end
      S_FX0: begin
        hctrl.fx0  = 1'b1;
        state_next = S_FX1;
      end
      S_FX1: begin
        hctrl.fx1  = 1'b1;
        state_next = S_FX2;
      end
      S_FX2: begin
        hctrl.fx2  = 1'b1;
        state_next = S_FX3;
      end
      S_FX3: begin
        hctrl.fx3  = 1'b1;
        state_next = (cmd_q == CMD_INSERT) ? S_W1 : S_R1;
      end
      S_W1: begin
        mem_we     = 1'b1;
        state_next = S_W2;
      end
      S_W2: begin
        mem_we     = 1'b1;
        mem_addr   = idx2;
        state_next = S_W3;
      end
      S_W3: begin
        mem_we      = 1'b1;
        mem_addr    = idx3;
        done_next   = 1'b1;
        hctrl.clear = 1'b1;
        state_next  = S_IDLE;
      end
      S_R1: begin
        state_next = S_R2;
      end
      S_R2: begin
        mem_addr   = idx2;
        state_next = S_R3;
      end
      S_R3: begin
        mem_addr   = idx3;
        state_next = S_R4;
      end
      S_R4: begin
        done_next   = 1'b1;
        found_next  = hit & rd_data;
        hctrl.clear = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_W3 || $past(state) == S_R4))
    else $error("result strobe without a finished transaction");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_insert_found: assert property (@(posedge clk) disable iff (rst)
    (done && result.was_insert) |-> !result.found)
    else $error("insert reported found");
  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (busy && mem_we && !mem_wdata))
    else $error("clearing pass not holding off transactions");
`endif

endmodule
